>>> design/erob_pkg.sv
// ----------------------------------------------------------------------------
// erob_pkg: shared definitions for the echo ranger with obstacle back-off
// Field widths, register indexes, item codes and the divide-by-58 constants.
// ----------------------------------------------------------------------------
package erob_pkg;

    // field widths
    localparam int TimeW  = 32;
    localparam int DistW  = 27;
    localparam int LimitW = 16;
    localparam int HalfW  = TimeW - 1;

    // configuration register indexes
    localparam logic REG_NEAR   = 1'b0;
    localparam logic REG_ESCAPE = 1'b1;

    // reset values of the limits
    localparam logic [LimitW-1:0] NEAR_RESET   = 16'd15;
    localparam logic [LimitW-1:0] ESCAPE_RESET = 16'd25;

    // input item kinds (carried on tuser)
    localparam logic OP_TRIGGER = 1'b0;
    localparam logic OP_EDGE    = 1'b1;

    // edges seen since the last trigger
    localparam logic [1:0] EDGES_NONE = 2'd0;
    localparam logic [1:0] EDGES_RISE = 2'd1;
    localparam logic [1:0] EDGES_DONE = 2'd2;

    // span / 58 = (span >> 1) / 29 = ((span >> 1) * RECIP_29) >> RECIP_SHIFT
    // exact for every 31-bit value: ceil(2^36 / 29) has an error term of 5
    localparam int               RECIP_SHIFT = 36;
    localparam logic [TimeW-1:0] RECIP_29    = 32'd2369637129;
    localparam int               ProdW       = HalfW + TimeW;

    // drive command codes
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_BACK = 2'd1,
        CMD_FWD  = 2'd2
    } t_drive_cmd;

endpackage

>>> design/echo_ranger_obstacle_backoff.sv
// ----------------------------------------------------------------------------
// echo_ranger_obstacle_backoff: ultrasonic echo range with back-off hysteresis
// Turns two captured echo edges into a distance in cm and issues reverse /
// forward commands with a near / escape threshold pair.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                    payload (low bit first)
//  s_axis    in   s_axis_tvalid/tready         tdata: capture_time[31:0],
//                                              moving_forward[32], pad to 40
//                                              tuser: opcode
//  m_axis    out  m_axis_tvalid/tready         tdata: distance_cm[26:0],
//                                              distance_new[27],
//                                              drive_command[29:28],
//                                              backing_off[30], pad to 32
//  cfg       in   i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
//  one request accepted per cycle unless a stalled output fills the stages;
//  its result passes the stage 1, stage 2 and output registers (edge bookkeeping
//  and subtract ahead of stage 1, reciprocal multiply, compare and update)
//  the 31x32 multiplier stands in its own stage
//  synchronous active-low reset clears edge count, back-off state and the last
//  distance and loads the limits with their reset values; no clearing pass
//  a stalled output fills the empty stages first, then drops s_axis_tready
//
module echo_ranger_obstacle_backoff (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // capture_time[31:0], moving_forward[32]
    input  logic        s_axis_tuser,   // opcode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // distance_cm[26:0], distance_new[27],
                                        // drive_command[29:28], backing_off[30]
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration
    logic [erob_pkg::LimitW-1:0] r_near_lim;
    logic [erob_pkg::LimitW-1:0] r_escape_lim;

    // first stage state and registers
    logic [1:0]                  r_edge_cnt;
    logic [erob_pkg::TimeW-1:0]  r_rise_time;
    logic                        r_s1_valid;
    logic                        r_s1_meas;
    logic                        r_s1_fwd;
    logic [erob_pkg::HalfW-1:0]  r_s1_half;

    // second stage
    logic                        r_s2_valid;
    logic                        r_s2_meas;
    logic                        r_s2_fwd;
    logic [erob_pkg::DistW-1:0]  r_s2_dist;

    // output stage and back-off state
    logic                        r_out_valid;
    logic                        r_out_new;
    erob_pkg::t_drive_cmd        r_out_cmd;
    logic                        r_retreat;
    logic [erob_pkg::DistW-1:0]  r_last_dist;

    // next values
    logic [1:0]                  n_edge_cnt;
    logic                        n_meas;
    logic                        n_retreat;
    erob_pkg::t_drive_cmd        n_cmd;

    logic                        w_rdy3;
    logic                        w_rdy2;
    logic                        w_rdy1;
    logic                        w_in_acc;
    logic                        w_opcode;
    logic [erob_pkg::TimeW-1:0]  w_stamp;
    logic                        w_fwd;
    logic [erob_pkg::TimeW-1:0]  w_span;
    logic [erob_pkg::ProdW-1:0]  w_prod;
    logic                        w_near_hit;
    logic                        w_escape_hit;

    // pipeline flow control: a stage takes a request when it is empty
    // or its content moves on
    assign w_rdy3        = !r_out_valid || m_axis_tready;
    assign w_rdy2        = !r_s2_valid || w_rdy3;
    assign w_rdy1        = !r_s1_valid || w_rdy2;
    assign s_axis_tready = w_rdy1;
    assign w_in_acc      = s_axis_tvalid && w_rdy1;

    assign w_opcode = s_axis_tuser;
    assign w_stamp  = s_axis_tdata[erob_pkg::TimeW-1:0];
    assign w_fwd    = s_axis_tdata[erob_pkg::TimeW];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_lim   <= erob_pkg::NEAR_RESET;
            r_escape_lim <= erob_pkg::ESCAPE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                erob_pkg::REG_NEAR:   r_near_lim   <= i_cfg_data;
                erob_pkg::REG_ESCAPE: r_escape_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // edge bookkeeping on the incoming request
    always_comb begin
        n_edge_cnt = r_edge_cnt;
        n_meas     = 1'b0;
        if (w_opcode == erob_pkg::OP_TRIGGER) begin
            n_edge_cnt = erob_pkg::EDGES_NONE;
        end else begin
            unique case (r_edge_cnt)
                erob_pkg::EDGES_NONE: n_edge_cnt = erob_pkg::EDGES_RISE;
                erob_pkg::EDGES_RISE: begin
                    n_edge_cnt = erob_pkg::EDGES_DONE;
                    n_meas     = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // wrapping pulse width
    assign w_span = w_stamp - r_rise_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_cnt  <= erob_pkg::EDGES_NONE;
            r_rise_time <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_edge_cnt <= n_edge_cnt;
                if (w_opcode == erob_pkg::OP_EDGE && r_edge_cnt == erob_pkg::EDGES_NONE) begin
                    r_rise_time <= w_stamp;
                end
            end
            if (w_rdy1) begin
                r_s1_valid <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_meas <= n_meas;
            r_s1_fwd  <= w_fwd;
            r_s1_half <= w_span[erob_pkg::TimeW-1:1];
        end
    end

    // divide by 58 through the reciprocal of 29
    assign w_prod = erob_pkg::ProdW'(r_s1_half) * erob_pkg::ProdW'(erob_pkg::RECIP_29);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_rdy2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_s1_valid) begin
            r_s2_meas <= r_s1_meas;
            r_s2_fwd  <= r_s1_fwd;
            r_s2_dist <= w_prod[erob_pkg::RECIP_SHIFT +: erob_pkg::DistW];
        end
    end

    // threshold decision with hysteresis
    assign w_near_hit   = r_s2_dist <= erob_pkg::DistW'(r_near_lim);
    assign w_escape_hit = r_s2_dist > erob_pkg::DistW'(r_escape_lim);

    always_comb begin
        n_cmd     = erob_pkg::CMD_NONE;
        n_retreat = r_retreat;
        if (r_s2_meas && r_s2_fwd) begin
            priority if (w_near_hit) begin
                n_cmd     = erob_pkg::CMD_BACK;
                n_retreat = 1'b1;
            end else if (w_escape_hit && r_retreat) begin
                n_cmd     = erob_pkg::CMD_FWD;
                n_retreat = 1'b0;
            end else begin
                n_cmd     = erob_pkg::CMD_NONE;
            end
        end
    end

    // output register and measurement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_retreat   <= 1'b0;
            r_last_dist <= '0;
        end else if (w_rdy3) begin
            r_out_valid <= r_s2_valid;
            if (r_s2_valid) begin
                r_retreat <= n_retreat;
                if (r_s2_meas) begin
                    r_last_dist <= r_s2_dist;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_s2_valid) begin
            r_out_new <= r_s2_meas;
            r_out_cmd <= n_cmd;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_retreat, r_out_cmd, r_out_new, r_last_dist};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // a reverse command always leaves the block backing off
    a_back_sets_retreat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cmd == erob_pkg::CMD_BACK) |-> r_retreat)
        else $error("reverse command without back-off state");

    // a forward command always ends backing off
    a_fwd_clears_retreat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cmd == erob_pkg::CMD_FWD) |-> !r_retreat)
        else $error("forward command while still backing off");

    // commands only come with a fresh measurement
    a_cmd_needs_meas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cmd != erob_pkg::CMD_NONE) |-> r_out_new)
        else $error("drive command without a completed measurement");

    // the edge counter holds at two until a trigger request
    a_edge_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_edge_cnt == erob_pkg::EDGES_DONE
         && !(w_in_acc && w_opcode == erob_pkg::OP_TRIGGER))
        |=> r_edge_cnt == erob_pkg::EDGES_DONE)
        else $error("edge counter left saturation without a trigger");

    // back-off state only moves when a request enters the output stage
    a_retreat_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_rdy3 && r_s2_valid) |=> $stable(r_retreat))
        else $error("back-off state changed without a request");

endmodule
